@@ hw/rtl/bcdau_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcdau_pkg
// Shared types, constants and BCD helpers of the decimal arithmetic unit.
// ----------------------------------------------------------------------------
package bcdau_pkg;

  localparam int unsigned Digits      = 14;
  localparam int unsigned DivFracDig  = 6;
  localparam int unsigned WorkDigits  = 36;
  localparam int unsigned WorkW       = 4 * WorkDigits;
  localparam int unsigned InW         = 4 * Digits;
  localparam int unsigned FracW       = 5;
  localparam int unsigned CntW        = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALIGN,
    ST_ADDSUB,
    ST_DIV_PRE,
    ST_DIV_SHIFT,
    ST_DIV_SUB,
    ST_DIV_END,
    ST_MUL_SHIFT,
    ST_MUL_ADD,
    ST_TRUNC,
    ST_TRIM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic shift_a;
    logic shift_b;
    logic add;
    logic sub;
    logic mul_shift;
    logic mul_add;
    logic div_shift;
    logic div_sub;
    logic div_set;
    logic div_end;
    logic shift_r;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic fa_lt_fb;
    logic fb_lt_fa;
    logic b_zero;
    logic r_ge_b;
    logic qcnt_zero;
    logic trunc_go;
    logic trim_go;
  } status_t;

  localparam logic [WorkW-1:0] Sixes = {WorkDigits{4'h6}};
  localparam logic [WorkW-1:0] Nines = {WorkDigits{4'h9}};

  // BCD add with carry in; top carry out is dropped
  function automatic logic [WorkW-1:0] bcd_add(input logic [WorkW-1:0] a,
                                               input logic [WorkW-1:0] b,
                                               input logic             cin);
    logic [WorkW:0]   s;
    logic [WorkW:0]   x;
    logic [WorkW-1:0] fix;
    s = {1'b0, a} + {1'b0, b} + {1'b0, Sixes} + {{WorkW{1'b0}}, cin};
    x = s ^ {1'b0, a} ^ {1'b0, b} ^ {1'b0, Sixes};
    for (int k = 0; k < WorkDigits; k++) begin
      fix[4*k +: 4] = x[4*k+4] ? 4'd0 : 4'd6;
    end
    return s[WorkW-1:0] - fix;
  endfunction

  // a - b for a >= b, via ten's complement
  function automatic logic [WorkW-1:0] bcd_sub(input logic [WorkW-1:0] a,
                                               input logic [WorkW-1:0] b);
    return bcd_add(a, Nines - b, 1'b1);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bcd_decimal_arithmetic_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_decimal_arithmetic_unit
// 14-digit BCD add, subtract, multiply and divide with decimal point handling.
// ----------------------------------------------------------------------------
// Usage: drive the opcode and both operands and raise start while busy is low;
// that edge is the input transfer. busy stays high until the result is shown.
// The result appears on the result ports for exactly one cycle with done_o
// high; the receiver must take it then, it cannot stall the unit.
// Sequence per operation, from the input transfer to the cycle with done_o:
//   add/sub : align fractions by |fa - fb| digit shifts, add or subtract,
//             then truncate and trim fraction digits
//   multiply: for each of 14 multiplier digits, shift once and add the
//             multiplicand digit-value times, then truncate and trim
//   divide  : align, pre-shift the dividend by DivFracDig digits, then for each
//             of 36 quotient digits shift and compare-and-subtract; divide by zero: straight to done
// The multiply loop does one BCD add per cycle and the long division loop
// one compare-and-subtract per cycle; one item at a time, the next transfer
// is taken in the cycle after done_o at the earliest.
// Reset returns the sequencer to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
module bcd_decimal_arithmetic_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  wire [1:0]                  opcode_i,
  input  wire [bcdau_pkg::InW-1:0]   operand_a_digits_i,
  input  wire [3:0]                  operand_a_frac_i,
  input  wire [bcdau_pkg::InW-1:0]   operand_b_digits_i,
  input  wire [3:0]                  operand_b_frac_i,
  output logic                       done_o,
  output logic [bcdau_pkg::InW-1:0]  result_digits_o,
  output logic [3:0]                 result_frac_o,
  output logic                       result_negative_o,
  output logic                       overflow_o,
  output logic                       divide_by_zero_o
);

  bcdau_pkg::cmd_t    cmd;
  bcdau_pkg::status_t status;

  bcdau_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  bcdau_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .opcode_i           (opcode_i),
    .operand_a_digits_i (operand_a_digits_i),
    .operand_a_frac_i   (operand_a_frac_i),
    .operand_b_digits_i (operand_b_digits_i),
    .operand_b_frac_i   (operand_b_frac_i),
    .result_digits_o    (result_digits_o),
    .result_frac_o      (result_frac_o),
    .result_negative_o  (result_negative_o),
    .overflow_o         (overflow_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bcdau_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcdau_datapath
// Operand, accumulator and fraction registers with the BCD add/sub unit.
// ----------------------------------------------------------------------------
module bcdau_datapath (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  bcdau_pkg::cmd_t                   cmd_i,
  output bcdau_pkg::status_t                status_o,
  input  wire [1:0]                         opcode_i,
  input  wire [bcdau_pkg::InW-1:0]          operand_a_digits_i,
  input  wire [3:0]                         operand_a_frac_i,
  input  wire [bcdau_pkg::InW-1:0]          operand_b_digits_i,
  input  wire [3:0]                         operand_b_frac_i,
  output logic [bcdau_pkg::InW-1:0]         result_digits_o,
  output logic [3:0]                        result_frac_o,
  output logic                              result_negative_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);

  localparam int unsigned WW = bcdau_pkg::WorkW;
  localparam int unsigned IW = bcdau_pkg::InW;

  logic [WW-1:0]               a_q, a_d, b_q, b_d, r_q, r_d;
  logic [3:0]                  fa_q, fa_d, fb_q, fb_d, qcnt_q, qcnt_d;
  logic [bcdau_pkg::FracW-1:0] f_q, f_d;
  bcdau_pkg::op_e              op_q, op_d;
  logic                        neg_q, neg_d, dbz_q, dbz_d;

  logic [WW-1:0] a_in, b_in, sum, diff_ab, diff_ba, r_plus_a, r_minus_b;
  logic [3:0]    fa_in, fb_in;
  logic          a_ge_b, high_nz, ovf;

  always_comb begin
    a_in = '0;
    b_in = '0;
    for (int i = 0; i < bcdau_pkg::Digits; i++) begin
      a_in[4*i +: 4] = (operand_a_digits_i[4*i +: 4] > 4'd9) ? 4'd9
                                                             : operand_a_digits_i[4*i +: 4];
      b_in[4*i +: 4] = (operand_b_digits_i[4*i +: 4] > 4'd9) ? 4'd9
                                                             : operand_b_digits_i[4*i +: 4];
    end
  end

  assign fa_in = (operand_a_frac_i > 4'(bcdau_pkg::Digits)) ? 4'(bcdau_pkg::Digits)
                                                            : operand_a_frac_i;
  assign fb_in = (operand_b_frac_i > 4'(bcdau_pkg::Digits)) ? 4'(bcdau_pkg::Digits)
                                                            : operand_b_frac_i;

  // clamped digits keep BCD order equal to binary order
  assign a_ge_b    = a_q >= b_q;
  assign sum       = bcdau_pkg::bcd_add(a_q, b_q, 1'b0);
  assign diff_ab   = bcdau_pkg::bcd_sub(a_q, b_q);
  assign diff_ba   = bcdau_pkg::bcd_sub(b_q, a_q);
  assign r_plus_a  = bcdau_pkg::bcd_add(r_q, a_q, 1'b0);
  assign r_minus_b = bcdau_pkg::bcd_sub(r_q, b_q);
  assign high_nz   = |r_q[WW-1:IW];

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    fa_d   = fa_q;
    fb_d   = fb_q;
    f_d    = f_q;
    qcnt_d = qcnt_q;
    op_d   = op_q;
    neg_d  = neg_q;
    dbz_d  = dbz_q;
    if (cmd_i.load) begin
      a_d    = a_in;
      b_d    = b_in;
      r_d    = '0;
      fa_d   = fa_in;
      fb_d   = fb_in;
      f_d    = {1'b0, fa_in} + {1'b0, fb_in};
      op_d   = bcdau_pkg::op_e'(opcode_i);
      neg_d  = 1'b0;
      dbz_d  = (opcode_i == bcdau_pkg::OP_DIV) && (b_in == '0);
      qcnt_d = '0;
    end
    if (cmd_i.shift_a) begin
      a_d  = {a_q[WW-5:0], 4'd0};
      fa_d = fa_q + 4'd1;
    end
    if (cmd_i.shift_b) begin
      b_d  = {b_q[WW-5:0], 4'd0};
      fb_d = fb_q + 4'd1;
    end
    if (cmd_i.add) begin
      r_d = sum;
      f_d = {1'b0, fa_q};
    end
    if (cmd_i.sub) begin
      r_d   = a_ge_b ? diff_ab : diff_ba;
      neg_d = !a_ge_b;
      f_d   = {1'b0, fa_q};
    end
    if (cmd_i.mul_shift) begin
      r_d    = {r_q[WW-5:0], 4'd0};
      qcnt_d = b_q[IW-1 -: 4];
      b_d    = {b_q[WW-5:0], 4'd0};
    end
    if (cmd_i.mul_add) begin
      r_d    = r_plus_a;
      qcnt_d = qcnt_q - 4'd1;
    end
    if (cmd_i.div_shift) begin
      r_d    = {r_q[WW-5:0], a_q[WW-1 -: 4]};
      a_d    = {a_q[WW-5:0], 4'd0};
      qcnt_d = '0;
    end
    if (cmd_i.div_sub) begin
      r_d    = r_minus_b;
      qcnt_d = qcnt_q + 4'd1;
    end
    if (cmd_i.div_set) begin
      a_d[3:0] = qcnt_q;
    end
    if (cmd_i.div_end) begin
      r_d = a_q;
      f_d = bcdau_pkg::FracW'(bcdau_pkg::DivFracDig);
    end
    if (cmd_i.shift_r) begin
      r_d = {4'd0, r_q[WW-1:4]};
      f_d = f_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= bcdau_pkg::OP_ADD;
      neg_q <= 1'b0;
      dbz_q <= 1'b0;
    end else begin
      op_q  <= op_d;
      neg_q <= neg_d;
      dbz_q <= dbz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    r_q    <= r_d;
    fa_q   <= fa_d;
    fb_q   <= fb_d;
    f_q    <= f_d;
    qcnt_q <= qcnt_d;
  end

  always_comb begin
    status_o.op        = op_q;
    status_o.fa_lt_fb  = fa_q < fb_q;
    status_o.fb_lt_fa  = fb_q < fa_q;
    status_o.b_zero    = dbz_q;
    status_o.r_ge_b    = r_q >= b_q;
    status_o.qcnt_zero = qcnt_q == '0;
    status_o.trunc_go  = (f_q != '0) &&
                         (high_nz || (f_q > bcdau_pkg::FracW'(bcdau_pkg::Digits)));
    status_o.trim_go   = (f_q != '0) && (r_q[3:0] == 4'd0);
  end

  assign ovf = high_nz && !dbz_q;

  always_comb begin
    result_digits_o   = (ovf || dbz_q) ? '0 : r_q[IW-1:0];
    result_frac_o     = (ovf || dbz_q) ? 4'd0 : f_q[3:0];
    result_negative_o = neg_q && (r_q != '0) && !ovf && !dbz_q;
    overflow_o        = ovf;
    divide_by_zero_o  = dbz_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/bcdau_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcdau_ctrl
// Sequencer: align, add/sub, shift-add multiply, long division, truncate, trim.
// ----------------------------------------------------------------------------
module bcdau_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  output logic                 done_o,
  output bcdau_pkg::cmd_t      cmd_o,
  input  bcdau_pkg::status_t   status_i
);

  bcdau_pkg::state_e            state_q, state_d;
  logic [bcdau_pkg::CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      bcdau_pkg::ST_IDLE: begin
        if (start) state_d = bcdau_pkg::ST_DISPATCH;
      end
      bcdau_pkg::ST_DISPATCH: begin
        if (status_i.op == bcdau_pkg::OP_MUL) begin
          state_d = bcdau_pkg::ST_MUL_SHIFT;
          cnt_d   = bcdau_pkg::CntW'(bcdau_pkg::Digits);
        end else if (status_i.b_zero) begin
          state_d = bcdau_pkg::ST_DONE;
        end else begin
          state_d = bcdau_pkg::ST_ALIGN;
        end
      end
      bcdau_pkg::ST_ALIGN: begin
        if (!status_i.fa_lt_fb && !status_i.fb_lt_fa) begin
          if (status_i.op == bcdau_pkg::OP_DIV) begin
            state_d = bcdau_pkg::ST_DIV_PRE;
            cnt_d   = bcdau_pkg::CntW'(bcdau_pkg::DivFracDig);
          end else begin
            state_d = bcdau_pkg::ST_ADDSUB;
          end
        end
      end
      bcdau_pkg::ST_ADDSUB: state_d = bcdau_pkg::ST_TRUNC;
      bcdau_pkg::ST_DIV_PRE: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = bcdau_pkg::ST_DIV_SHIFT;
          cnt_d   = bcdau_pkg::CntW'(bcdau_pkg::WorkDigits);
        end
      end
      bcdau_pkg::ST_DIV_SHIFT: begin
        state_d = bcdau_pkg::ST_DIV_SUB;
        cnt_d   = cnt_q - 1'b1;
      end
      bcdau_pkg::ST_DIV_SUB: begin
        if (!status_i.r_ge_b) begin
          state_d = (cnt_q == '0) ? bcdau_pkg::ST_DIV_END : bcdau_pkg::ST_DIV_SHIFT;
        end
      end
      bcdau_pkg::ST_DIV_END: state_d = bcdau_pkg::ST_TRUNC;
      bcdau_pkg::ST_MUL_SHIFT: begin
        state_d = bcdau_pkg::ST_MUL_ADD;
        cnt_d   = cnt_q - 1'b1;
      end
      bcdau_pkg::ST_MUL_ADD: begin
        if (status_i.qcnt_zero) begin
          state_d = (cnt_q == '0) ? bcdau_pkg::ST_TRUNC : bcdau_pkg::ST_MUL_SHIFT;
        end
      end
      bcdau_pkg::ST_TRUNC: begin
        if (!status_i.trunc_go) state_d = bcdau_pkg::ST_TRIM;
      end
      bcdau_pkg::ST_TRIM: begin
        if (!status_i.trim_go) state_d = bcdau_pkg::ST_DONE;
      end
      bcdau_pkg::ST_DONE: state_d = bcdau_pkg::ST_IDLE;
      default: state_d = bcdau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    done_o = 1'b0;
    busy   = state_q != bcdau_pkg::ST_IDLE;
    unique case (state_q)
      bcdau_pkg::ST_IDLE:      cmd_o.load = start;
      bcdau_pkg::ST_DISPATCH:  ;
      bcdau_pkg::ST_ALIGN: begin
        cmd_o.shift_a = status_i.fa_lt_fb;
        cmd_o.shift_b = status_i.fb_lt_fa;
      end
      bcdau_pkg::ST_ADDSUB: begin
        cmd_o.add = status_i.op == bcdau_pkg::OP_ADD;
        cmd_o.sub = status_i.op != bcdau_pkg::OP_ADD;
      end
      bcdau_pkg::ST_DIV_PRE:   cmd_o.shift_a = cnt_q != '0;
      bcdau_pkg::ST_DIV_SHIFT: cmd_o.div_shift = 1'b1;
      bcdau_pkg::ST_DIV_SUB: begin
        cmd_o.div_sub = status_i.r_ge_b;
        cmd_o.div_set = !status_i.r_ge_b;
      end
      bcdau_pkg::ST_DIV_END:   cmd_o.div_end = 1'b1;
      bcdau_pkg::ST_MUL_SHIFT: cmd_o.mul_shift = 1'b1;
      bcdau_pkg::ST_MUL_ADD:   cmd_o.mul_add = !status_i.qcnt_zero;
      bcdau_pkg::ST_TRUNC:     cmd_o.shift_r = status_i.trunc_go;
      bcdau_pkg::ST_TRIM:      cmd_o.shift_r = status_i.trim_go;
      bcdau_pkg::ST_DONE:      done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcdau_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcdau_pkg::ST_DONE |=> state_q == bcdau_pkg::ST_IDLE)
    else $error("done not followed by idle");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.add, cmd_o.sub, cmd_o.mul_shift, cmd_o.mul_add,
              cmd_o.div_shift, cmd_o.div_sub, cmd_o.div_set, cmd_o.div_end,
              cmd_o.shift_r}))
    else $error("conflicting datapath commands");

  a_div_shift_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcdau_pkg::ST_DIV_SHIFT |=> state_q == bcdau_pkg::ST_DIV_SUB)
    else $error("division step skipped compare");
`endif

endmodule
`default_nettype wire
